/* rtl/sssa_pkg.sv */
// Shared types, field layout constants and fixed-point helpers of the state-score accumulator.
package sssa_pkg;

   localparam int MAX_LABELS    = 32;
   localparam int FEATURE_SLOTS = 4096;
   localparam int ATTRIBUTES    = 1024;

   localparam int Q_W        = 32;
   localparam int LABEL_W    = $clog2(MAX_LABELS);
   localparam int SLOT_W     = $clog2(FEATURE_SLOTS);
   localparam int ATTR_W     = $clog2(ATTRIBUTES);
   localparam int COUNT_W    = SLOT_W + 1;
   localparam int LCOUNT_W   = 6;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_TDATA_W = 120;
   localparam int RSP_TDATA_W = 40;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_LABEL_COUNT  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GLOBAL_SCALE = 1'd1;

   typedef enum logic [1:0] {
      REQ_LOAD_SLOT = 2'd0,
      REQ_LOAD_ATTR = 2'd1,
      REQ_CONTENT   = 2'd2,
      REQ_END_POS   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ATTR,
      ST_FEAT,
      ST_LBL,
      ST_ACC,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic                  clip;
      logic signed [Q_W-1:0] val;
   } qval_type;

   // Drops the low 16 of the 32 fraction bits of a Q32.32 product (floor) and saturates to 32 bits.
   function automatic qval_type qscale(input logic signed [2*Q_W-1:0] p);
      logic signed [2*Q_W-17:0] sh;
      qval_type                 r;
      sh = 48'(p >>> 16);
      r.clip = 1'b0;
      r.val  = sh[Q_W-1:0];
      if (sh[2*Q_W-17:Q_W-1] != '0 && sh[2*Q_W-17:Q_W-1] != '1) begin
         r.clip = 1'b1;
         r.val  = sh[2*Q_W-17] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      end
      return r;
   endfunction

   // Saturating add of two Q16.16 values.
   function automatic qval_type qadd(input logic signed [Q_W-1:0] a,
                                     input logic signed [Q_W-1:0] b);
      logic signed [Q_W:0] s;
      qval_type            r;
      s = 33'(a) + 33'(b);
      r.clip = 1'b0;
      r.val  = s[Q_W-1:0];
      if (s[Q_W] != s[Q_W-1]) begin
         r.clip = 1'b1;
         r.val  = s[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

/* rtl/sparse_state_score_accumulator.sv */
// Top level of the sparse state-score accumulator: tables, sequencer and score memory.
// A load request writes its table entry when accepted. A content item reads and scales the
// attribute, then per slot does the feature read, the weight multiply and the score
// read-modify-write on one sequencer. An end of position emits each label in turn as a score
// read and an output step that waits while the result channel stalls. Requests never overlap.
// Synchronous active-high reset clears the sequencer, output register and score valid bits and
// restores label_count to 32 and global_scale to 1.0; the two tables are not cleared.
module sparse_state_score_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata, lowest bit up: feature_slot[11:0], slot_label[16:12], slot_weight[48:17],
   // attr_id[58:49], list_start[70:59], list_count[83:71], content_scale[115:84], zeros.
   input  logic [sssa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: req_type[1:0].
   input  logic [1:0]                          req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata, lowest bit up: label_index[4:0], score[36:5], zeros.
   output logic [sssa_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // rsp_tuser: saturated[0].
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [sssa_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sssa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sssa_pkg::*;

   // Request field unpacking.
   logic [SLOT_W-1:0]     f_feature_slot;
   logic [LABEL_W-1:0]    f_slot_label;
   logic signed [Q_W-1:0] f_slot_weight;
   logic [ATTR_W-1:0]     f_attr_id;
   logic [SLOT_W-1:0]     f_list_start;
   logic [COUNT_W-1:0]    f_list_count;
   logic signed [Q_W-1:0] f_content_scale;
   req_kind_type          f_kind;

   assign f_feature_slot  = req_tdata[11:0];
   assign f_slot_label    = req_tdata[16:12];
   assign f_slot_weight   = req_tdata[48:17];
   assign f_attr_id       = req_tdata[58:49];
   assign f_list_start    = req_tdata[70:59];
   assign f_list_count    = req_tdata[83:71];
   assign f_content_scale = req_tdata[115:84];
   assign f_kind          = req_kind_type'(req_tuser);

   // Configuration registers.
   logic [LCOUNT_W-1:0]   label_count_ff;
   logic signed [Q_W-1:0] global_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         label_count_ff  <= LCOUNT_W'(MAX_LABELS);
         global_scale_ff <= 32'sd65536;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LABEL_COUNT:  label_count_ff  <= csr_wdata[LCOUNT_W-1:0];
            CSR_GLOBAL_SCALE: global_scale_ff <= csr_wdata[Q_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer state and datapath registers.
   state_type                 state_ff, state_in;
   logic signed [2*Q_W-1:0]   sprod_ff;     // content_scale * global_scale
   logic signed [Q_W-1:0]     value_ff;     // scaled content value
   logic [COUNT_W-1:0]        slot_ff;      // next slot of the walk, top bit marks overflow
   logic [COUNT_W-1:0]        remain_ff;    // slots still to visit
   logic signed [2*Q_W-1:0]   mprod_ff;     // weight * value
   logic [LABEL_W-1:0]        label_ff;
   logic [LABEL_W-1:0]        k_ff;         // label being emitted
   logic [MAX_LABELS-1:0]     valid_ff;     // score entry written since the last clear

   // Memories and their registered read data.
   logic [LABEL_W+Q_W-1:0]    feat_mem_ff  [FEATURE_SLOTS];
   logic [COUNT_W+SLOT_W-1:0] attr_mem_ff  [ATTRIBUTES];
   logic [Q_W:0]              score_mem_ff [MAX_LABELS];
   logic [LABEL_W+Q_W-1:0]    feat_rdata_ff;
   logic [COUNT_W+SLOT_W-1:0] attr_rdata_ff;
   logic [Q_W:0]              score_rdata_ff;

   // Output register.
   logic                      rsp_valid_ff;
   logic [LABEL_W-1:0]        rsp_label_ff;
   logic signed [Q_W-1:0]     rsp_score_ff;
   logic                      rsp_sat_ff;
   logic                      rsp_last_ff;

   // Combinational control.
   logic                      accept;
   logic                      walk_done;
   logic                      out_room;
   logic                      emit_last;
   logic [LABEL_W-1:0]        last_k;
   logic [LCOUNT_W-1:0]       lc_m1;
   logic [LABEL_W-1:0]        score_raddr;
   logic                      score_we;
   logic [LABEL_W-1:0]        feat_label;
   logic signed [Q_W-1:0]     feat_weight;
   logic signed [Q_W-1:0]     old_score;
   logic                      old_sat;
   qval_type                  acc_prod;
   qval_type                  acc_sum;
   qval_type                  scaled;

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign walk_done   = (remain_ff == '0) || slot_ff[COUNT_W-1];
   assign out_room    = !rsp_valid_ff || rsp_tready;
   assign feat_label  = feat_rdata_ff[LABEL_W+Q_W-1:Q_W];
   assign feat_weight = feat_rdata_ff[Q_W-1:0];

   // Number of emitted labels: label_count, but at least one and at most MAX_LABELS.
   assign lc_m1 = label_count_ff - LCOUNT_W'(1);
   always_comb begin
      if (label_count_ff == '0) begin
         last_k = '0;
      end else if (label_count_ff > LCOUNT_W'(MAX_LABELS)) begin
         last_k = LABEL_W'(MAX_LABELS - 1);
      end else begin
         last_k = lc_m1[LABEL_W-1:0];
      end
   end
   assign emit_last = (k_ff == last_k);

   // Accumulate step: an entry not written since the last clear reads as zero.
   assign old_score = valid_ff[label_ff] ? score_rdata_ff[Q_W-1:0] : '0;
   assign old_sat   = valid_ff[label_ff] ? score_rdata_ff[Q_W] : 1'b0;
   assign acc_prod  = qscale(mprod_ff);
   assign acc_sum   = qadd(old_score, acc_prod.val);
   assign scaled    = qscale(sprod_ff);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && f_kind == REQ_CONTENT) begin
               state_in = ST_ATTR;
            end else if (accept && f_kind == REQ_END_POS) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_ATTR:    state_in = ST_FEAT;
         ST_FEAT:    state_in = walk_done ? ST_IDLE : ST_LBL;
         ST_LBL:     state_in = ST_ACC;
         ST_ACC:     state_in = ST_FEAT;
         ST_EMIT_RD: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (out_room) begin
               state_in = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Output and strobe decode.
   always_comb begin
      score_we    = 1'b0;
      score_raddr = feat_label;
      case (state_ff)
         ST_ACC:      score_we    = 1'b1;
         ST_EMIT_RD:  score_raddr = k_ff;
         ST_EMIT_OUT: score_raddr = k_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Feature table: written by slot loads, read for each visited slot.
   always_ff @(posedge clock) begin
      if (accept && f_kind == REQ_LOAD_SLOT) begin
         feat_mem_ff[f_feature_slot] <= {f_slot_label, f_slot_weight};
      end
      feat_rdata_ff <= feat_mem_ff[slot_ff[SLOT_W-1:0]];
   end

   // Attribute table: written by attribute loads, read when a content item is taken.
   always_ff @(posedge clock) begin
      if (accept && f_kind == REQ_LOAD_ATTR) begin
         attr_mem_ff[f_attr_id] <= {f_list_count, f_list_start};
      end
      attr_rdata_ff <= attr_mem_ff[f_attr_id];
   end

   // Score memory: the write of one slot, in ST_ACC, lands before the next slot's read in ST_LBL,
   // with ST_FEAT between, so consecutive slots that hit the same label need no forwarding.
   always_ff @(posedge clock) begin
      if (score_we) begin
         score_mem_ff[label_ff] <= {old_sat | acc_prod.clip | acc_sum.clip, acc_sum.val};
      end
      score_rdata_ff <= score_mem_ff[score_raddr];
   end

   // Walk datapath.
   always_ff @(posedge clock) begin
      if (accept) begin
         sprod_ff <= f_content_scale * global_scale_ff;
      end
      case (state_ff)
         ST_ATTR: begin
            value_ff  <= scaled.val;
            slot_ff   <= {1'b0, attr_rdata_ff[SLOT_W-1:0]};
            remain_ff <= attr_rdata_ff[COUNT_W+SLOT_W-1:SLOT_W];
         end
         ST_FEAT: begin
            if (!walk_done) begin
               slot_ff   <= slot_ff + COUNT_W'(1);
               remain_ff <= remain_ff - COUNT_W'(1);
            end
         end
         ST_LBL: begin
            mprod_ff <= feat_weight * value_ff;
            label_ff <= feat_label;
         end
         default: ;
      endcase
   end

   // Score valid bits and emit counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         k_ff     <= '0;
      end else begin
         if (score_we) begin
            valid_ff[label_ff] <= 1'b1;
         end
         if (state_ff == ST_EMIT_OUT && out_room) begin
            if (emit_last) begin
               valid_ff <= '0;
               k_ff     <= '0;
            end else begin
               k_ff <= k_ff + LABEL_W'(1);
            end
         end
      end
   end

   // Output register: loaded while the sequencer emits, drained by the downstream side.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT_OUT && out_room) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT_OUT && out_room) begin
         rsp_label_ff <= k_ff;
         rsp_score_ff <= valid_ff[k_ff] ? score_rdata_ff[Q_W-1:0] : '0;
         rsp_sat_ff   <= valid_ff[k_ff] ? score_rdata_ff[Q_W] : 1'b0;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_score_ff, rsp_label_ff};
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
